/* rtl/svg_pkg.sv */
// Shared types and constants for the sphere vertex generator.
// Used by every module of the block but the checker; depends on nothing.
package svg_pkg;

    parameter int MAX_GRID_POINTS = 1024;

    parameter int CNT_W = 11;
    parameter int IDX_W = 10;
    parameter int ANG_W = 32;
    parameter int POS_W = 32;
    parameter int RAD_W = 31;
    parameter int TEX_W = 16;
    parameter int NRM_W = 16;
    parameter int CFG_DATA_W = 32;
    parameter int CFG_IDX_W = 3;

    // Divider lanes: numerator is shifted through, remainder fits the doubled count.
    parameter int DIV_NUM_W = 44;
    parameter int DIV_STEP = 4;
    parameter int DIV_REM_W = 11;
    parameter int DIV_LANES = 4;
    parameter int LANE_THETA = 0;
    parameter int LANE_PHI = 1;
    parameter int LANE_U = 2;
    parameter int LANE_V = 3;

    // CORDIC datapath, Q2.30 with headroom.
    parameter int CORDIC_W = 34;
    parameter int TRIG_W = 32;
    parameter logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
    parameter logic signed [CORDIC_W-1:0] Q30_POS = 34'sd1073741824;
    parameter logic signed [CORDIC_W-1:0] Q30_NEG = -34'sd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_COLUMNS  = 3'd4,
        CFG_ROWS     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_z;
        logic [RAD_W-1:0]        radius;
    } vec_cfg_t;

    // Arctangent of 2^-i in binary turns (2^32 per full turn).
    function automatic logic [29:0] atan_turn(input int unsigned i);
        case (i)
            0:  return 30'd536870912;
            1:  return 30'd316933406;
            2:  return 30'd167458907;
            3:  return 30'd85004756;
            4:  return 30'd42667331;
            5:  return 30'd21354465;
            6:  return 30'd10679838;
            7:  return 30'd5340245;
            8:  return 30'd2670163;
            9:  return 30'd1335087;
            10: return 30'd667544;
            11: return 30'd333772;
            12: return 30'd166886;
            13: return 30'd83443;
            14: return 30'd41722;
            15: return 30'd20861;
            16: return 30'd10430;
            17: return 30'd5215;
            18: return 30'd2608;
            19: return 30'd1304;
            20: return 30'd652;
            21: return 30'd326;
            22: return 30'd163;
            23: return 30'd81;
            24: return 30'd41;
            25: return 30'd20;
            26: return 30'd10;
            27: return 30'd5;
            28: return 30'd3;
            29: return 30'd1;
            30: return 30'd1;
            default: return 30'd0;
        endcase
    endfunction

endpackage

/* rtl/svg_div.sv */
// Pipelined restoring divider, several lanes sharing one valid chain.
// Retires DIV_STEP quotient bits per stage; depends on svg_pkg.
module svg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic [svg_pkg::DIV_NUM_W-1:0] num_in [svg_pkg::DIV_LANES],
    input  logic [svg_pkg::DIV_REM_W-1:0] den_in [svg_pkg::DIV_LANES],
    output logic                          valid_out,
    output logic [svg_pkg::DIV_NUM_W-1:0] quo_out [svg_pkg::DIV_LANES]
);

    localparam int W = svg_pkg::DIV_NUM_W;
    localparam int R = svg_pkg::DIV_REM_W;
    localparam int L = svg_pkg::DIV_LANES;
    localparam int STAGES = svg_pkg::DIV_NUM_W / svg_pkg::DIV_STEP;

    typedef struct packed {
        logic [W-1:0] work;
        logic [R-1:0] rem;
    } step_t;

    // The work word shifts the numerator out at the top and the quotient in at the bottom.
    function automatic step_t div_step(input logic [W-1:0] w_in, input logic [R-1:0] r_in,
                                       input logic [R-1:0] d);
        logic [W-1:0] w;
        logic [R-1:0] r;
        logic [R:0]   t;
        w = w_in;
        r = r_in;
        for (int k = 0; k < svg_pkg::DIV_STEP; k++)
        begin
            t = {r, w[W-1]};
            w = {w[W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                r = R'(t - {1'b0, d});
                w[0] = 1'b1;
            end
            else
            begin
                r = t[R-1:0];
            end
        end
        return '{work: w, rem: r};
    endfunction

    logic [STAGES-1:0] valid_reg;
    logic [W-1:0]      work_reg [STAGES][L];
    logic [R-1:0]      rem_reg  [STAGES-1][L];
    logic [R-1:0]      den_reg  [STAGES-1][L];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[STAGES-2:0], valid_in};
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        for (genvar l = 0; l < L; l++)
        begin : g_lane
            logic [W-1:0] w_src;
            logic [R-1:0] r_src;
            logic [R-1:0] d_src;
            step_t        step_next;

            if (s == 0)
            begin : g_first
                assign w_src = num_in[l];
                assign r_src = '0;
                assign d_src = den_in[l];
            end
            else
            begin : g_rest
                assign w_src = work_reg[s-1][l];
                assign r_src = rem_reg[s-1][l];
                assign d_src = den_reg[s-1][l];
            end

            assign step_next = div_step(w_src, r_src, d_src);

            always_ff @(posedge clk)
            begin
                work_reg[s][l] <= step_next.work;
            end

            if (s < STAGES - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[s][l] <= step_next.rem;
                    den_reg[s][l] <= d_src;
                end
            end
        end
    end

    for (genvar l = 0; l < L; l++)
    begin : g_out
        assign quo_out[l] = work_reg[STAGES-1][l];
    end

    assign valid_out = valid_reg[STAGES-1];

endmodule

/* rtl/svg_cordic.sv */
// Two-lane pipelined CORDIC in rotation mode, one iteration per stage.
// Takes angles in binary turns and gives clamped Q2.30 cosine and sine; depends on svg_pkg.
module svg_cordic #(
    parameter int STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid_in,
    input  logic [svg_pkg::ANG_W-1:0]         angle_in [2],
    output logic                              valid_out,
    output logic signed [svg_pkg::TRIG_W-1:0] cos_out [2],
    output logic signed [svg_pkg::TRIG_W-1:0] sin_out [2]
);

    localparam int W = svg_pkg::CORDIC_W;

    logic [STEPS+1:0]    valid_reg;
    logic signed [W-1:0] x_reg [STEPS+1][2];
    logic signed [W-1:0] y_reg [STEPS+1][2];
    logic signed [W-1:0] z_reg [STEPS][2];
    logic                flip_reg [STEPS+1][2];
    logic signed [svg_pkg::TRIG_W-1:0] cos_reg [2];
    logic signed [svg_pkg::TRIG_W-1:0] sin_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[STEPS:0], valid_in};
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic flip_in;
        logic signed [W-1:0] x_fin;
        logic signed [W-1:0] y_fin;

        // Angles in the left half plane are rotated by half a turn and negated later.
        assign flip_in = (angle_in[l] > 32'h4000_0000) && (angle_in[l] < 32'hC000_0000);

        always_ff @(posedge clk)
        begin
            x_reg[0][l]    <= svg_pkg::CORDIC_X0;
            y_reg[0][l]    <= '0;
            z_reg[0][l]    <= W'($signed({angle_in[l][31] ^ flip_in, angle_in[l][30:0]}));
            flip_reg[0][l] <= flip_in;
        end

        for (genvar s = 0; s < STEPS; s++)
        begin : g_iter
            logic                dir_pos;
            logic signed [W-1:0] dx;
            logic signed [W-1:0] dy;

            assign dir_pos = ~z_reg[s][l][W-1];
            assign dx = y_reg[s][l] >>> s;
            assign dy = x_reg[s][l] >>> s;

            always_ff @(posedge clk)
            begin
                x_reg[s+1][l]    <= dir_pos ? x_reg[s][l] - dx : x_reg[s][l] + dx;
                y_reg[s+1][l]    <= dir_pos ? y_reg[s][l] + dy : y_reg[s][l] - dy;
                flip_reg[s+1][l] <= flip_reg[s][l];
            end

            if (s < STEPS - 1)
            begin : g_angle
                logic signed [W-1:0] step_ang;
                assign step_ang = W'(svg_pkg::atan_turn(s));
                always_ff @(posedge clk)
                begin
                    z_reg[s+1][l] <= dir_pos ? z_reg[s][l] - step_ang
                                             : z_reg[s][l] + step_ang;
                end
            end
        end

        assign x_fin = flip_reg[STEPS][l] ? -x_reg[STEPS][l] : x_reg[STEPS][l];
        assign y_fin = flip_reg[STEPS][l] ? -y_reg[STEPS][l] : y_reg[STEPS][l];

        always_ff @(posedge clk)
        begin
            if (x_fin > svg_pkg::Q30_POS)
                cos_reg[l] <= svg_pkg::TRIG_W'(svg_pkg::Q30_POS);
            else if (x_fin < svg_pkg::Q30_NEG)
                cos_reg[l] <= svg_pkg::TRIG_W'(svg_pkg::Q30_NEG);
            else
                cos_reg[l] <= x_fin[svg_pkg::TRIG_W-1:0];

            if (y_fin > svg_pkg::Q30_POS)
                sin_reg[l] <= svg_pkg::TRIG_W'(svg_pkg::Q30_POS);
            else if (y_fin < svg_pkg::Q30_NEG)
                sin_reg[l] <= svg_pkg::TRIG_W'(svg_pkg::Q30_NEG);
            else
                sin_reg[l] <= y_fin[svg_pkg::TRIG_W-1:0];
        end

        assign cos_out[l] = cos_reg[l];
        assign sin_out[l] = sin_reg[l];
    end

    assign valid_out = valid_reg[STEPS+1];

endmodule

/* rtl/svg_vec.sv */
// Vertex assembly: unit vector products, radius scaling, normals and saturation.
// Four register stages after the CORDIC outputs; depends on svg_pkg.
module svg_vec (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid_in,
    input  logic signed [svg_pkg::TRIG_W-1:0] cos_theta,
    input  logic signed [svg_pkg::TRIG_W-1:0] sin_theta,
    input  logic signed [svg_pkg::TRIG_W-1:0] cos_phi,
    input  logic signed [svg_pkg::TRIG_W-1:0] sin_phi,
    input  logic [svg_pkg::TEX_W-1:0]         tex_u_in,
    input  logic [svg_pkg::TEX_W-1:0]         tex_v_in,
    input  svg_pkg::vec_cfg_t                 cfg,
    output logic                              valid_out,
    output logic signed [svg_pkg::POS_W-1:0]  position_x,
    output logic signed [svg_pkg::POS_W-1:0]  position_y,
    output logic signed [svg_pkg::POS_W-1:0]  position_z,
    output logic [svg_pkg::TEX_W-1:0]         tex_u,
    output logic [svg_pkg::TEX_W-1:0]         tex_v,
    output logic signed [svg_pkg::NRM_W-1:0]  normal_x,
    output logic signed [svg_pkg::NRM_W-1:0]  normal_y,
    output logic signed [svg_pkg::NRM_W-1:0]  normal_z
);

    localparam int TW = svg_pkg::TRIG_W;
    localparam int NW = svg_pkg::NRM_W;
    localparam int PW = svg_pkg::POS_W;

    logic [3:0] valid_reg;

    logic signed [63:0]   pxy_reg [2];
    logic signed [TW-1:0] uz1_reg;
    logic signed [TW-1:0] u_reg [3];
    logic signed [63:0]   prod_reg [3];
    logic signed [NW-1:0] nrm3_reg [3];
    logic signed [NW-1:0] nrm4_reg [3];
    logic signed [PW-1:0] pos_reg [3];
    logic [svg_pkg::TEX_W-1:0] tu_reg [4];
    logic [svg_pkg::TEX_W-1:0] tv_reg [4];

    logic signed [PW-1:0] center [3];
    logic signed [TW-1:0] radius_s;

    assign center[0] = cfg.center_x;
    assign center[1] = cfg.center_y;
    assign center[2] = cfg.center_z;
    assign radius_s  = $signed({1'b0, cfg.radius});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        pxy_reg[0] <= sin_phi * cos_theta;
        pxy_reg[1] <= sin_phi * sin_theta;
        uz1_reg    <= cos_phi;
        tu_reg[0]  <= tex_u_in;
        tv_reg[0]  <= tex_v_in;
        for (int k = 1; k < 4; k++)
        begin
            tu_reg[k] <= tu_reg[k-1];
            tv_reg[k] <= tv_reg[k-1];
        end
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_unit
        logic signed [63:0] rounded;
        assign rounded = (pxy_reg[a] + 64'sd536870912) >>> 30;
        always_ff @(posedge clk)
        begin
            u_reg[a] <= rounded[TW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg[2] <= uz1_reg;
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [TW:0]   nrm_sum;
        logic signed [TW:0]   nrm_shift;
        logic signed [NW-1:0] nrm_sat;
        logic signed [63:0]   off_full;
        logic signed [PW+1:0] pos_sum;

        assign nrm_sum   = {u_reg[a][TW-1], u_reg[a]} + 33'sd32768;
        assign nrm_shift = nrm_sum >>> 16;

        always_comb
        begin
            if (nrm_shift > 33'sd16384)
                nrm_sat = 16'sd16384;
            else if (nrm_shift < -33'sd16384)
                nrm_sat = -16'sd16384;
            else
                nrm_sat = nrm_shift[NW-1:0];
        end

        assign off_full = (prod_reg[a] + 64'sd536870912) >>> 30;
        assign pos_sum  = {{2{center[a][PW-1]}}, center[a]} + off_full[PW+1:0];

        always_ff @(posedge clk)
        begin
            prod_reg[a] <= radius_s * u_reg[a];
            nrm3_reg[a] <= nrm_sat;
            nrm4_reg[a] <= nrm3_reg[a];
            if (pos_sum > 34'sd2147483647)
                pos_reg[a] <= 32'sh7FFF_FFFF;
            else if (pos_sum < -34'sd2147483648)
                pos_reg[a] <= 32'sh8000_0000;
            else
                pos_reg[a] <= pos_sum[PW-1:0];
        end
    end

    assign valid_out  = valid_reg[3];
    assign position_x = pos_reg[0];
    assign position_y = pos_reg[1];
    assign position_z = pos_reg[2];
    assign normal_x   = nrm4_reg[0];
    assign normal_y   = nrm4_reg[1];
    assign normal_z   = nrm4_reg[2];
    assign tex_u      = tu_reg[3];
    assign tex_v      = tv_reg[3];

endmodule

/* rtl/sphere_vertex_generator.sv */
// Top level of the sphere vertex generator: configuration registers, index clamp,
// divider, CORDIC and vertex stages. Depends on svg_pkg, svg_div, svg_cordic, svg_vec.
//
// Usage: raise start with row_index and column_index; a transaction is accepted at
// each clock edge where start is high and busy is low. busy stays low, so one grid
// point can enter every cycle. Each result appears for exactly one cycle with
// result_valid high, and results leave in the order the points entered. Each
// point passes the index clamp stage, the 11-stage divider (four quotient bits
// per stage), one CORDIC stage per iteration plus its pre- and post-stages,
// and four vertex stages.
// Configuration is written on the cfg_valid/cfg_ready channel (cfg_ready is always
// high) by register index; write it only while no point is in flight.
// Reset clears all pipeline valid bits and loads center 0, radius 1.0 and
// 16 by 16 grid counts. The receiver cannot stall, so the pipeline never holds.
module sphere_vertex_generator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [svg_pkg::IDX_W-1:0]             row_index,
    input  logic [svg_pkg::IDX_W-1:0]             column_index,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [svg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [svg_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  result_valid,
    output logic signed [svg_pkg::POS_W-1:0]      position_x,
    output logic signed [svg_pkg::POS_W-1:0]      position_y,
    output logic signed [svg_pkg::POS_W-1:0]      position_z,
    output logic [svg_pkg::TEX_W-1:0]             tex_u,
    output logic [svg_pkg::TEX_W-1:0]             tex_v,
    output logic signed [svg_pkg::NRM_W-1:0]      normal_x,
    output logic signed [svg_pkg::NRM_W-1:0]      normal_y,
    output logic signed [svg_pkg::NRM_W-1:0]      normal_z
);

    localparam int IW = svg_pkg::IDX_W;
    localparam int CW = svg_pkg::CNT_W;
    localparam int TEX_DLY = CORDIC_STEPS + 2;

    svg_pkg::vec_cfg_t   cfg_reg;
    logic [CW-1:0]       column_count_reg;
    logic [CW-1:0]       row_count_reg;

    logic [IW-1:0] cm_next;
    logic [IW-1:0] rm_next;
    logic [IW-1:0] col_next;
    logic [IW-1:0] row_next;

    logic          front_valid_reg;
    logic [IW-1:0] cm_reg;
    logic [IW-1:0] rm_reg;
    logic [IW-1:0] col_reg;
    logic [IW-1:0] row_reg;

    logic [svg_pkg::DIV_NUM_W-1:0] div_num [svg_pkg::DIV_LANES];
    logic [svg_pkg::DIV_REM_W-1:0] div_den [svg_pkg::DIV_LANES];
    logic [svg_pkg::DIV_NUM_W-1:0] div_quo [svg_pkg::DIV_LANES];
    logic                          div_valid;

    logic [svg_pkg::ANG_W-1:0]         angle [2];
    logic signed [svg_pkg::TRIG_W-1:0] cos_val [2];
    logic signed [svg_pkg::TRIG_W-1:0] sin_val [2];
    logic                              cordic_valid;

    logic [svg_pkg::TEX_W-1:0] tu_dly_reg [TEX_DLY];
    logic [svg_pkg::TEX_W-1:0] tv_dly_reg [TEX_DLY];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.center_z <= '0;
            cfg_reg.radius   <= svg_pkg::RAD_W'(65536);
            column_count_reg <= CW'(16);
            row_count_reg    <= CW'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (svg_pkg::cfg_index_t'(cfg_index))
                svg_pkg::CFG_CENTER_X: cfg_reg.center_x <= cfg_data;
                svg_pkg::CFG_CENTER_Y: cfg_reg.center_y <= cfg_data;
                svg_pkg::CFG_CENTER_Z: cfg_reg.center_z <= cfg_data;
                svg_pkg::CFG_RADIUS:   cfg_reg.radius   <= cfg_data[svg_pkg::RAD_W-1:0];
                svg_pkg::CFG_COLUMNS:  column_count_reg <= cfg_data[CW-1:0];
                svg_pkg::CFG_ROWS:     row_count_reg    <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts minus one, then clamp the indices to the last grid line.
    always_comb
    begin
        if (column_count_reg < CW'(2))
            cm_next = IW'(1);
        else if (column_count_reg > CW'(svg_pkg::MAX_GRID_POINTS))
            cm_next = IW'(svg_pkg::MAX_GRID_POINTS - 1);
        else
            cm_next = IW'(column_count_reg - CW'(1));

        if (row_count_reg < CW'(2))
            rm_next = IW'(1);
        else if (row_count_reg > CW'(svg_pkg::MAX_GRID_POINTS))
            rm_next = IW'(svg_pkg::MAX_GRID_POINTS - 1);
        else
            rm_next = IW'(row_count_reg - CW'(1));

        col_next = (column_index > cm_next) ? cm_next : column_index;
        row_next = (row_index > rm_next) ? rm_next : row_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        cm_reg  <= cm_next;
        rm_reg  <= rm_next;
        col_reg <= col_next;
        row_reg <= row_next;
    end

    // Rounded quotients: (index * 2^k + m) / (2 * m) for each angle and texture lane.
    assign div_num[svg_pkg::LANE_THETA] = {1'b0, col_reg, 23'd0, cm_reg};
    assign div_num[svg_pkg::LANE_PHI]   = {2'b0, row_reg, 22'd0, rm_reg};
    assign div_num[svg_pkg::LANE_U]     = {18'd0, col_reg, 6'd0, cm_reg};
    assign div_num[svg_pkg::LANE_V]     = {18'd0, row_reg, 6'd0, rm_reg};
    assign div_den[svg_pkg::LANE_THETA] = {cm_reg, 1'b0};
    assign div_den[svg_pkg::LANE_PHI]   = {rm_reg, 1'b0};
    assign div_den[svg_pkg::LANE_U]     = {cm_reg, 1'b0};
    assign div_den[svg_pkg::LANE_V]     = {rm_reg, 1'b0};

    svg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (front_valid_reg),
        .num_in    (div_num),
        .den_in    (div_den),
        .valid_out (div_valid),
        .quo_out   (div_quo)
    );

    // A full turn of theta wraps to zero through the truncation.
    assign angle[0] = div_quo[svg_pkg::LANE_THETA][svg_pkg::ANG_W-1:0];
    assign angle[1] = div_quo[svg_pkg::LANE_PHI][svg_pkg::ANG_W-1:0];

    svg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (div_valid),
        .angle_in  (angle),
        .valid_out (cordic_valid),
        .cos_out   (cos_val),
        .sin_out   (sin_val)
    );

    always_ff @(posedge clk)
    begin
        tu_dly_reg[0] <= div_quo[svg_pkg::LANE_U][svg_pkg::TEX_W-1:0];
        tv_dly_reg[0] <= div_quo[svg_pkg::LANE_V][svg_pkg::TEX_W-1:0];
        for (int k = 1; k < TEX_DLY; k++)
        begin
            tu_dly_reg[k] <= tu_dly_reg[k-1];
            tv_dly_reg[k] <= tv_dly_reg[k-1];
        end
    end

    svg_vec u_vec (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (cordic_valid),
        .cos_theta  (cos_val[0]),
        .sin_theta  (sin_val[0]),
        .cos_phi    (cos_val[1]),
        .sin_phi    (sin_val[1]),
        .tex_u_in   (tu_dly_reg[TEX_DLY-1]),
        .tex_v_in   (tv_dly_reg[TEX_DLY-1]),
        .cfg        (cfg_reg),
        .valid_out  (result_valid),
        .position_x (position_x),
        .position_y (position_y),
        .position_z (position_z),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z)
    );

endmodule

/* rtl/svg_checker.sv */
// Port-level checker for the sphere vertex generator, bound to the top level.
// Depends only on the top level's ports and its CORDIC_STEPS parameter.
module svg_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [15:0] tex_u,
    input logic [15:0] tex_v,
    input logic [15:0] normal_z
);

    localparam int LATENCY = CORDIC_STEPS + 18;

    // Every accepted transaction yields a result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("accepted transaction produced no result");

    // No result appears without a matching accepted transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted transaction");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (tex_u <= 16'd32768) && (tex_v <= 16'd32768))
        else $error("texture coordinate above one");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(normal_z) <= 16'sd16384) &&
                         ($signed(normal_z) >= -16'sd16384))
        else $error("normal component outside unit range");

endmodule

bind sphere_vertex_generator svg_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_svg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .normal_z     (normal_z)
);
